// File: src/round_robin_slot_scheduler_top_macros.svh
// ============================================================================
// Assertion macros for the round-robin slot scheduler
// Shared property templates, clocked on clk and disabled while in reset.
// ============================================================================
`ifndef ROUND_ROBIN_SLOT_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_SLOT_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication.
`define RRS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication.
`define RRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// File: src/rrs_pkg.sv
// ============================================================================
// rrs_pkg
// Types, sizes and codes shared by the round-robin slot scheduler modules.
// ============================================================================
package rrs_pkg;

    // Table geometry.
    localparam int SLOTS     = 64;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int ID_BITS   = 16;

    // Field widths of the request and response.
    localparam int MODE_W  = 2;
    localparam int TID_W   = 16;
    localparam int WGT_W   = 16;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int WSUM_W  = 22;

    // Thread ids are kept modulo 2^ID_BITS.
    localparam logic [TID_W-1:0] ID_MASK = TID_W'((64'd1 << ID_BITS) - 64'd1);

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd3;

    // Response status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_NONE     = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TID_W-1:0]  thread_id;
        logic [WGT_W-1:0]  weight;
        logic              blocked_flag;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot_index;
        logic [TID_W-1:0]   chosen_thread;
        logic               has_current_out;
        logic               switched;
        logic [COUNT_W-1:0] thread_count;
        logic [WSUM_W-1:0]  weight_sum;
    } rsp_t;

    // One entry of the slot RAM.
    typedef struct packed {
        logic [TID_W-1:0] id;
        logic [WGT_W-1:0] weight;
    } ram_word_t;

    // Access command from the engine to the slot RAM.
    typedef struct packed {
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_addr;
        ram_word_t            wr_data;
    } ram_cmd_t;

endpackage

// File: src/rrs_slot_ram.sv
// ============================================================================
// rrs_slot_ram
// One-port-write, one-port-read synchronous RAM holding the id and weight of
// each slot. Read data is registered and holds while no read is enabled.
// ============================================================================
module rrs_slot_ram
    import rrs_pkg::*;
(
    input  logic      clk,
    input  ram_cmd_t  cmd,
    output ram_word_t rd_data
);

    ram_word_t mem [SLOTS];
    ram_word_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/rrs_engine.sv
// ============================================================================
// rrs_engine
// Sequencer of the scheduler: scans the slot RAM for an id and a free slot,
// scans the runnable flags round-robin for a tick, then commits the update
// and presents one response.
// ============================================================================
module rrs_engine
    import rrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  req_t      in_req,
    output logic      res_valid,
    input  logic      res_ready,
    output rsp_t      res,
    output ram_cmd_t  ram_cmd,
    input  ram_word_t ram_rd_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FSCAN = 3'd1;
    localparam logic [2:0] S_TSCAN = 3'd2;
    localparam logic [2:0] S_TREAD = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    // Sequencer and scan state.
    logic [2:0]           state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [SLOT_BITS-1:0] cnt_reg, cnt_next;
    logic                 hit_reg, hit_next;
    logic [SLOT_BITS-1:0] hit_idx_reg, hit_idx_next;
    logic [WGT_W-1:0]     hit_w_reg, hit_w_next;
    logic                 free_reg, free_next;
    logic [SLOT_BITS-1:0] free_idx_reg, free_idx_next;
    logic                 found_reg, found_next;

    // Architectural scheduler state.
    logic [SLOTS-1:0]     used_reg, used_next;
    logic [SLOTS-1:0]     blocked_reg, blocked_next;
    logic [SLOT_BITS-1:0] last_reg, last_next;
    logic                 has_cur_reg, has_cur_next;
    logic [TID_W-1:0]     cur_reg, cur_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [WSUM_W-1:0]    wsum_reg, wsum_next;

    // Commit values computed while finishing.
    logic [STAT_W-1:0]    fin_status;
    logic [SLOT_BITS-1:0] fin_slot;
    logic                 fin_sw;
    logic                 fin_has_cur;
    logic [TID_W-1:0]     fin_cur;
    logic [COUNT_W-1:0]   fin_count;
    logic [WSUM_W-1:0]    fin_wsum;
    logic [SLOTS-1:0]     fin_used;
    logic [SLOTS-1:0]     fin_blocked;
    logic [SLOT_BITS-1:0] fin_last;
    logic                 fin_wr;

    function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] x);
        return (x == LAST_SLOT) ? '0 : SLOT_BITS'(x + 1'b1);
    endfunction

    // Outcome of the request, from the scan results and the held RAM data.
    always_comb
    begin
        fin_status  = ST_OK;
        fin_slot    = '0;
        fin_sw      = 1'b0;
        fin_has_cur = has_cur_reg;
        fin_cur     = cur_reg;
        fin_count   = count_reg;
        fin_wsum    = wsum_reg;
        fin_used    = used_reg;
        fin_blocked = blocked_reg;
        fin_last    = last_reg;
        fin_wr      = 1'b0;
        unique case (req_reg.mode)
            MODE_ENQ:
            begin
                if (hit_reg)
                begin
                    fin_status = ST_DUP;
                    fin_slot   = hit_idx_reg;
                end
                else if (!free_reg)
                begin
                    fin_status = ST_FULL;
                end
                else
                begin
                    fin_wr                      = 1'b1;
                    fin_used[free_idx_reg]      = 1'b1;
                    fin_blocked[free_idx_reg]   = 1'b0;
                    fin_count = COUNT_W'(count_reg + 1'b1);
                    fin_wsum  = WSUM_W'(wsum_reg + WSUM_W'(req_reg.weight));
                    fin_slot  = free_idx_reg;
                end
            end
            MODE_DEQ:
            begin
                if (!hit_reg)
                begin
                    fin_status = ST_NOTFOUND;
                end
                else
                begin
                    fin_used[hit_idx_reg] = 1'b0;
                    fin_count = COUNT_W'(count_reg - 1'b1);
                    fin_wsum  = WSUM_W'(wsum_reg - WSUM_W'(hit_w_reg));
                    fin_slot  = hit_idx_reg;
                end
            end
            MODE_BLK:
            begin
                if (!hit_reg)
                begin
                    fin_status = ST_NOTFOUND;
                end
                else
                begin
                    fin_blocked[hit_idx_reg] = req_reg.blocked_flag;
                    fin_slot                 = hit_idx_reg;
                end
            end
            MODE_TICK:
            begin
                if (!found_reg)
                begin
                    fin_status  = ST_NONE;
                    fin_last    = '0;
                    fin_has_cur = 1'b0;
                end
                else if (has_cur_reg && idx_reg == last_reg)
                begin
                    fin_slot = idx_reg;
                end
                else
                begin
                    fin_has_cur = 1'b1;
                    fin_cur     = ram_rd_data.id;
                    fin_last    = idx_reg;
                    fin_sw      = 1'b1;
                    fin_slot    = idx_reg;
                end
            end
        endcase
    end

    // Response fields.
    always_comb
    begin
        res.status          = fin_status;
        res.slot_index      = SLOT_W'(fin_slot);
        res.chosen_thread   = fin_has_cur ? fin_cur : '0;
        res.has_current_out = fin_has_cur;
        res.switched        = fin_sw;
        res.thread_count    = fin_count;
        res.weight_sum      = fin_wsum;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_w_next    = hit_w_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        found_next    = found_reg;
        used_next     = used_reg;
        blocked_next  = blocked_reg;
        last_next     = last_reg;
        has_cur_next  = has_cur_reg;
        cur_next      = cur_reg;
        count_next    = count_reg;
        wsum_next     = wsum_reg;
        ram_cmd       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next           = in_req;
                    req_next.thread_id = in_req.thread_id & ID_MASK;
                    hit_next           = 1'b0;
                    free_next          = 1'b0;
                    found_next         = 1'b0;
                    cnt_next           = '0;
                    if (in_req.mode == MODE_TICK)
                    begin
                        idx_next   = slot_inc(last_reg);
                        state_next = S_TSCAN;
                    end
                    else
                    begin
                        idx_next        = '0;
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = '0;
                        state_next      = S_FSCAN;
                    end
                end
            end
            S_FSCAN:
            begin
                // RAM data belongs to idx_reg; the next read is issued alongside.
                if (!used_reg[idx_reg] && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (used_reg[idx_reg] && ram_rd_data.id == req_reg.thread_id)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    hit_w_next   = ram_rd_data.weight;
                    state_next   = S_FIN;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next        = slot_inc(idx_reg);
                    ram_cmd.rd_en   = 1'b1;
                    ram_cmd.rd_addr = slot_inc(idx_reg);
                end
            end
            S_TSCAN:
            begin
                // One candidate slot per cycle, previous pick checked last.
                if (used_reg[idx_reg] && !blocked_reg[idx_reg])
                begin
                    found_next      = 1'b1;
                    ram_cmd.rd_en   = 1'b1;
                    ram_cmd.rd_addr = idx_reg;
                    state_next      = S_TREAD;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next = slot_inc(idx_reg);
                    cnt_next = SLOT_BITS'(cnt_reg + 1'b1);
                end
            end
            S_TREAD:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    used_next       = fin_used;
                    blocked_next    = fin_blocked;
                    last_next       = fin_last;
                    has_cur_next    = fin_has_cur;
                    cur_next        = fin_cur;
                    count_next      = fin_count;
                    wsum_next       = fin_wsum;
                    ram_cmd.wr_en   = fin_wr;
                    ram_cmd.wr_addr = free_idx_reg;
                    ram_cmd.wr_data = '{id: req_reg.thread_id, weight: req_reg.weight};
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and scheduler state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            found_reg   <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            used_reg    <= '0;
            blocked_reg <= '0;
            last_reg    <= '0;
            has_cur_reg <= 1'b0;
            cur_reg     <= '0;
            count_reg   <= '0;
            wsum_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            found_reg   <= found_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            used_reg    <= used_next;
            blocked_reg <= blocked_next;
            last_reg    <= last_next;
            has_cur_reg <= has_cur_next;
            cur_reg     <= cur_next;
            count_reg   <= count_next;
            wsum_reg    <= wsum_next;
        end
    end

    // Request payload and scan results.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        hit_idx_reg  <= hit_idx_next;
        hit_w_reg    <= hit_w_next;
        free_idx_reg <= free_idx_next;
    end

endmodule

// File: src/round_robin_slot_scheduler_top.sv
// ============================================================================
// round_robin_slot_scheduler_top
// Slot table scheduler: enqueue, dequeue, set-blocked and round-robin tick,
// one response per request.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_ready   in_data  (req_t)
//   out       output     out_valid / out_ready out_data (rsp_t)
//
// Enqueue, dequeue and set-blocked scan the slot RAM one entry per cycle,
// stopping at a matching id. A tick scans the runnable flags one slot per cycle
// and then reads the chosen slot's id from the RAM.
// Reset clears all slot flags and counters at once; no clearing pass is run.
// The response sits in an output register, so a new request is taken while it
// waits; a stalled output holds the engine only when a second response is due.
// ============================================================================
`include "round_robin_slot_scheduler_top_macros.svh"

module round_robin_slot_scheduler_top
    import rrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    ram_cmd_t  ram_cmd;
    ram_word_t ram_rd_data;
    logic      res_valid;
    logic      res_ready;
    rsp_t      res;
    logic      out_valid_reg;
    rsp_t      out_data_reg;
    logic      switch_ok;
    logic      idle_ok;

    rrs_slot_ram u_ram (
        .clk     (clk),
        .cmd     (ram_cmd),
        .rd_data (ram_rd_data)
    );

    rrs_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_req      (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_cmd     (ram_cmd),
        .ram_rd_data (ram_rd_data)
    );

    // Output register: free when empty or being taken this cycle.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Response properties checked by the assertions below.
    assign switch_ok = out_data.has_current_out && (out_data.status == ST_OK);
    assign idle_ok   = !out_data.has_current_out && (out_data.slot_index == '0)
                       && (out_data.chosen_thread == '0);

    // The engine is busy right after taking a request.
    `RRS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A switch only comes with a successful pick of a current thread.
    `RRS_ASSERT_IMPL(a_switch_ok, out_valid && out_data.switched, switch_ok)
    // Nothing runnable leaves no current thread and reports slot zero.
    `RRS_ASSERT_IMPL(a_idle_clears, out_valid && out_data.status == ST_NONE, idle_ok)

endmodule
